// ----- design/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/bbc_pkg.sv -----
// ---------------------------------------------------------------------------
// bbc_pkg
// types, character codes and decode for the bracket balance checker
// ---------------------------------------------------------------------------
package bbc_pkg;

   typedef logic [1:0] kind_type;

   localparam int unsigned KIND_W = 2;

   localparam kind_type KIND_ROUND  = 2'd0;
   localparam kind_type KIND_SQUARE = 2'd1;
   localparam kind_type KIND_CURLY  = 2'd2;

   localparam logic [7:0] CHAR_OPEN_ROUND   = 8'h28;
   localparam logic [7:0] CHAR_CLOSE_ROUND  = 8'h29;
   localparam logic [7:0] CHAR_OPEN_SQUARE  = 8'h5B;
   localparam logic [7:0] CHAR_CLOSE_SQUARE = 8'h5D;
   localparam logic [7:0] CHAR_OPEN_CURLY   = 8'h7B;
   localparam logic [7:0] CHAR_CLOSE_CURLY  = 8'h7D;

   typedef struct packed {
      logic     is_open;
      logic     is_close;
      kind_type kind;
   } char_class_type;

   typedef struct packed {
      logic balanced;
      logic stack_overflow;
   } verdict_type;

   function automatic char_class_type classify(input logic [7:0] code);
      char_class_type cls;
      cls = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_ROUND};
      unique case (code)
         CHAR_OPEN_ROUND: begin
            cls.is_open = 1'b1;
            cls.kind    = KIND_ROUND;
         end
         CHAR_OPEN_SQUARE: begin
            cls.is_open = 1'b1;
            cls.kind    = KIND_SQUARE;
         end
         CHAR_OPEN_CURLY: begin
            cls.is_open = 1'b1;
            cls.kind    = KIND_CURLY;
         end
         CHAR_CLOSE_ROUND: begin
            cls.is_close = 1'b1;
            cls.kind     = KIND_ROUND;
         end
         CHAR_CLOSE_SQUARE: begin
            cls.is_close = 1'b1;
            cls.kind     = KIND_SQUARE;
         end
         CHAR_CLOSE_CURLY: begin
            cls.is_close = 1'b1;
            cls.kind     = KIND_CURLY;
         end
         default: begin
            cls.is_open = 1'b0;
         end
      endcase
      return cls;
   endfunction

endpackage

// ----- design/bbc_if.sv -----
// ---------------------------------------------------------------------------
// bbc_req_if / bbc_rsp_if
// valid/ready channels for character input and verdict output
// ---------------------------------------------------------------------------
interface bbc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       is_final;

   modport source (output valid, output char_code, output is_final, input ready);
   modport sink   (input valid, input char_code, input is_final, output ready);
endinterface

interface bbc_rsp_if;
   logic valid;
   logic ready;
   logic balanced;
   logic stack_overflow;

   modport source (output valid, output balanced, output stack_overflow, input ready);
   modport sink   (input valid, input balanced, input stack_overflow, output ready);
endinterface

// ----- design/bracket_balance_checker.sv -----
// ---------------------------------------------------------------------------
// bracket_balance_checker
// checks that round, square and curly brackets in a byte string nest and
// match; one verdict transfer per string, on its final byte
//
//   channel   dir  payload                       transfer when
//   req_chan  in   char_code[7:0], is_final      valid && ready
//   rsp_chan  out  balanced, stack_overflow      valid && ready
//
// one byte per cycle sustained unless a verdict is held; the top of stack is cached in a register
// and the ram is read one entry below it every cycle, so pops in
// consecutive cycles need no stall
// a verdict appears on rsp_chan the cycle after the final byte's transfer
// req_chan stalls only while a verdict waits and rsp_chan.ready is low
// synchronous reset clears level and flags; stack ram needs no clearing
// ---------------------------------------------------------------------------
module bracket_balance_checker
   import bbc_pkg::*;
#(
   parameter int unsigned STACK_DEPTH = 64
) (
   input  logic      clock,
   input  logic      reset,
   bbc_req_if.sink   req_chan,
   bbc_rsp_if.source rsp_chan
);

   logic        accept;
   logic        can_load;
   logic        verdict_valid;
   verdict_type verdict;

   assign req_chan.ready = can_load;
   assign accept         = req_chan.valid && can_load;

   bbc_stack_ctrl #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack_ctrl (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .char_code     (req_chan.char_code),
      .is_final      (req_chan.is_final),
      .verdict_valid (verdict_valid),
      .verdict       (verdict)
   );

   bbc_rsp_stage u_rsp_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (verdict_valid),
      .verdict  (verdict),
      .can_load (can_load),
      .rsp_chan (rsp_chan)
   );

endmodule

// ----- design/bbc_ram.sv -----
// ---------------------------------------------------------------------------
// bbc_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module bbc_ram #(
   parameter int unsigned WIDTH = 2,
   parameter int unsigned DEPTH = 64,
   parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/bbc_stack_ctrl.sv -----
// ---------------------------------------------------------------------------
// bbc_stack_ctrl
// stack level, cached top of stack, fail flags and verdict generation;
// the stack body lives in a ram read one entry below the top each cycle
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bbc_stack_ctrl
   import bbc_pkg::*;
#(
   parameter int unsigned STACK_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [7:0]  char_code,
   input  logic        is_final,
   output logic        verdict_valid,
   output verdict_type verdict
);

   localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int unsigned LW = $clog2(STACK_DEPTH + 1);
   localparam logic [LW-1:0] LEVEL_FULL = LW'(STACK_DEPTH);

   logic [LW-1:0]  level_ff, level_in;
   logic           failed_ff, failed_in;
   logic           overflow_ff, overflow_in;
   kind_type       top_kind_ff, top_kind_in;
   logic           use_mem_ff, use_mem_in;

   char_class_type cls;
   kind_type       top_kind;
   kind_type       rd_data;
   logic           active;
   logic           do_push;
   logic           do_pop;
   logic           push_full;
   logic           close_bad;
   logic [LW-1:0]  level_next;
   logic           failed_next;
   logic           overflow_next;

   assign cls      = classify(char_code);
   assign top_kind = use_mem_ff ? rd_data : top_kind_ff;
   assign active   = accept && !failed_ff;

   assign do_push   = active && cls.is_open && (level_ff != LEVEL_FULL);
   assign push_full = active && cls.is_open && (level_ff == LEVEL_FULL);
   assign do_pop    = active && cls.is_close && (level_ff != '0) && (top_kind == cls.kind);
   assign close_bad = active && cls.is_close && !((level_ff != '0) && (top_kind == cls.kind));

   bbc_ram #(
      .WIDTH (KIND_W),
      .DEPTH (STACK_DEPTH),
      .AW    (AW)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (do_push),
      .wr_addr (AW'(level_ff)),
      .wr_data (cls.kind),
      .rd_addr (AW'(level_ff - LW'(2))),
      .rd_data (rd_data)
   );

   always_comb begin
      level_next    = level_ff;
      failed_next   = failed_ff || push_full || close_bad;
      overflow_next = overflow_ff || push_full;
      top_kind_in   = top_kind;
      use_mem_in    = 1'b0;
      if (do_push) begin
         level_next  = level_ff + LW'(1);
         top_kind_in = cls.kind;
      end else if (do_pop) begin
         level_next = level_ff - LW'(1);
         use_mem_in = 1'b1;
      end

      verdict_valid          = accept && is_final;
      verdict.balanced       = !failed_next && (level_next == '0);
      verdict.stack_overflow = overflow_next;

      level_in    = level_next;
      failed_in   = failed_next;
      overflow_in = overflow_next;
      if (accept && is_final) begin
         level_in    = '0;
         failed_in   = 1'b0;
         overflow_in = 1'b0;
         use_mem_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff    <= '0;
         failed_ff   <= 1'b0;
         overflow_ff <= 1'b0;
         use_mem_ff  <= 1'b0;
      end else begin
         level_ff    <= level_in;
         failed_ff   <= failed_in;
         overflow_ff <= overflow_in;
         use_mem_ff  <= use_mem_in;
      end
   end

   always_ff @(posedge clock) begin
      top_kind_ff <= top_kind_in;
   end

   `ASSERT_ALWAYS(a_level_bound, clock, reset, level_ff <= LEVEL_FULL,
      "stack level beyond depth")

   `ASSERT_ALWAYS(a_overflow_fails, clock, reset, !overflow_ff || failed_ff,
      "overflow without failure")

   `ASSERT_NEXT(a_final_clears, clock, reset, accept && is_final,
      level_ff == '0 && !failed_ff && !overflow_ff, "string state not cleared")

   `ASSERT_NEXT(a_pop_reads_mem, clock, reset, do_pop && !is_final && level_ff > LW'(1),
      use_mem_ff, "new top not taken from ram after pop")

endmodule

// ----- design/bbc_rsp_stage.sv -----
// ---------------------------------------------------------------------------
// bbc_rsp_stage
// output register holding one verdict until the downstream transfer
// ---------------------------------------------------------------------------
module bbc_rsp_stage
   import bbc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  verdict_type verdict,
   output logic        can_load,
   bbc_rsp_if.source   rsp_chan
);

   logic        valid_ff, valid_in;
   verdict_type data_ff, data_in;

   assign can_load = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff && !rsp_chan.ready;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_chan.valid          = valid_ff;
   assign rsp_chan.balanced       = data_ff.balanced;
   assign rsp_chan.stack_overflow = data_ff.stack_overflow;

endmodule
